// File: design/cabn_pkg.sv
// Shared types and constants for the class-aware box suppression block.
`timescale 1ns / 1ps
package cabn_pkg;

    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 96;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_IOU_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_W     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_H     = 3'd7;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_R_RDI, ST_R_LDI, ST_R_RDJ, ST_R_CMP, ST_R_WR,
        ST_N_RDI, ST_N_RDIB, ST_N_LDA, ST_N_RDJ, ST_N_RDJB, ST_N_CMP, ST_N_WAIT, ST_N_DEC,
        ST_E_RD, ST_E_RDB, ST_E_CHK, ST_E_WAIT, ST_E_RES, ST_E_PUSH, ST_E_FIN
    } state_t;

    typedef struct packed {
        logic store_we;
        logic a_load;
        logic order_we;
        logic sup_set;
        logic box_sel_order;
        logic res_load;
        logic pend_load;
        logic out_load;
        logic out_last;
        logic out_empty;
    } cmd_t;

    typedef struct packed {
        logic class_ok;
        logic score_gt;
        logic score_eq;
        logic class_eq;
        logic sup_bit;
        logic overlap;
        logic keep_ok;
        logic out_free;
    } stat_t;

endpackage

// File: design/cabn_ctrl.sv
// Sequencer for load, rank, suppression and emit phases.
`timescale 1ns / 1ps
module cabn_ctrl #(
    parameter int MAX_CANDIDATES = 256,
    parameter int MAX_KEPT = 64,
    localparam int IW = $clog2(MAX_CANDIDATES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  cabn_pkg::stat_t   stat,
    output cabn_pkg::cmd_t    cmd,
    output logic [IW-1:0]     pos,
    output logic [IW-1:0]     box_idx,
    output logic [IW-1:0]     ord_addr,
    output logic [IW-1:0]     ord_val
);
    import cabn_pkg::*;

    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam int KW = $clog2(MAX_KEPT + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [CW-1:0]   rank_reg, rank_next;
    logic [KW-1:0]   kept_reg, kept_next;
    logic            pend_reg, pend_next;
    logic [1:0]      wait_reg, wait_next;
    logic [CW-1:0]   i_inc, j_inc;

    assign i_inc = i_reg + CW'(1);
    assign j_inc = j_reg + CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            rank_reg  <= '0;
            kept_reg  <= '0;
            pend_reg  <= 1'b0;
            wait_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            rank_reg  <= rank_next;
            kept_reg  <= kept_next;
            pend_reg  <= pend_next;
            wait_reg  <= wait_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        rank_next  = rank_reg;
        kept_next  = kept_reg;
        pend_next  = pend_reg;
        wait_next  = wait_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        pos        = i_reg[IW-1:0];
        box_idx    = i_reg[IW-1:0];
        ord_addr   = rank_reg[IW-1:0];
        ord_val    = i_reg[IW-1:0];

        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                pos = cnt_reg[IW-1:0];
                if (s_tvalid) begin
                    if (cnt_reg != CW'(MAX_CANDIDATES) && stat.class_ok) begin
                        cmd.store_we = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (s_tlast) begin
                        i_next = '0;
                        kept_next = '0;
                        pend_next = 1'b0;
                        state_next = (cnt_next == '0) ? ST_E_FIN : ST_R_RDI;
                    end
                end
            end
            ST_R_RDI: state_next = ST_R_LDI;
            ST_R_LDI: begin
                cmd.a_load = 1'b1;
                j_next = '0;
                rank_next = '0;
                state_next = ST_R_RDJ;
            end
            ST_R_RDJ: begin
                box_idx = j_reg[IW-1:0];
                state_next = ST_R_CMP;
            end
            ST_R_CMP: begin
                box_idx = j_reg[IW-1:0];
                if (stat.score_gt || (stat.score_eq && j_reg < i_reg))
                    rank_next = rank_reg + CW'(1);
                j_next = j_inc;
                state_next = (j_inc == cnt_reg) ? ST_R_WR : ST_R_RDJ;
            end
            ST_R_WR: begin
                cmd.order_we = 1'b1;
                if (i_inc == cnt_reg) begin
                    i_next = '0;
                    state_next = ST_N_RDI;
                end else begin
                    i_next = i_inc;
                    state_next = ST_R_RDI;
                end
            end
            ST_N_RDI: state_next = ST_N_RDIB;
            ST_N_RDIB: begin
                cmd.box_sel_order = 1'b1;
                if (!stat.sup_bit) begin
                    state_next = ST_N_LDA;
                end else if (i_inc == cnt_reg) begin
                    i_next = '0;
                    state_next = ST_E_RD;
                end else begin
                    i_next = i_inc;
                    state_next = ST_N_RDI;
                end
            end
            ST_N_LDA: begin
                cmd.box_sel_order = 1'b1;
                cmd.a_load = 1'b1;
                j_next = i_inc;
                if (i_inc == cnt_reg) begin
                    i_next = '0;
                    state_next = ST_E_RD;
                end else begin
                    state_next = ST_N_RDJ;
                end
            end
            ST_N_RDJ, ST_N_RDJB, ST_N_CMP, ST_N_WAIT, ST_N_DEC: begin
                pos = j_reg[IW-1:0];
                cmd.box_sel_order = 1'b1;
                if (state_reg == ST_N_RDJ) begin
                    state_next = ST_N_RDJB;
                end else if (state_reg == ST_N_WAIT) begin
                    wait_next = wait_reg + 2'd1;
                    if (wait_reg == 2'd2)
                        state_next = ST_N_DEC;
                end else if (state_reg == ST_N_CMP && stat.class_eq) begin
                    wait_next = '0;
                    state_next = ST_N_WAIT;
                end else if (state_reg == ST_N_RDJB && !stat.sup_bit) begin
                    state_next = ST_N_CMP;
                end else begin
                    // next pair: reached on skip or after the decision
                    cmd.sup_set = (state_reg == ST_N_DEC) && stat.overlap;
                    j_next = j_inc;
                    if (j_inc != cnt_reg) begin
                        state_next = ST_N_RDJ;
                    end else if (i_inc == cnt_reg) begin
                        i_next = '0;
                        state_next = ST_E_RD;
                    end else begin
                        i_next = i_inc;
                        state_next = ST_N_RDI;
                    end
                end
            end
            ST_E_RD: state_next = ST_E_RDB;
            ST_E_RDB, ST_E_CHK, ST_E_WAIT, ST_E_RES, ST_E_PUSH: begin
                cmd.box_sel_order = 1'b1;
                if (state_reg == ST_E_RDB) begin
                    state_next = ST_E_CHK;
                end else if (state_reg == ST_E_WAIT) begin
                    state_next = ST_E_RES;
                end else if (state_reg == ST_E_RES) begin
                    cmd.res_load = 1'b1;
                    state_next = ST_E_PUSH;
                end else if (state_reg == ST_E_CHK && stat.keep_ok) begin
                    state_next = ST_E_WAIT;
                end else if (state_reg == ST_E_PUSH && pend_reg && !stat.out_free) begin
                    state_next = ST_E_PUSH;
                end else begin
                    if (state_reg == ST_E_PUSH) begin
                        cmd.pend_load = 1'b1;
                        cmd.out_load = pend_reg;
                        pend_next = 1'b1;
                        kept_next = kept_reg + KW'(1);
                    end
                    i_next = i_inc;
                    state_next = (i_inc == cnt_reg || kept_next == KW'(MAX_KEPT)) ?
                                 ST_E_FIN : ST_E_RD;
                end
            end
            ST_E_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_empty = !pend_reg;
                    cnt_next = '0;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

endmodule

// File: design/cabn_dp.sv
// Datapath: box stores, overlap pipeline, coordinate mapping, output register.
`timescale 1ns / 1ps
module cabn_dp #(
    parameter int MAX_CANDIDATES = 256,
    parameter int NUM_CLASSES = 80,
    localparam int IW = $clog2(MAX_CANDIDATES)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [cabn_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 cfg_we,
    input  logic [cabn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cabn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  cabn_pkg::cmd_t                       cmd,
    input  logic [IW-1:0]                        pos,
    input  logic [IW-1:0]                        box_idx,
    input  logic [IW-1:0]                        ord_addr,
    input  logic [IW-1:0]                        ord_val,
    output cabn_pkg::stat_t                      stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cabn_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [cabn_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                 m_tlast
);
    import cabn_pkg::*;

    function automatic logic [11:0] clamp_pix(input logic signed [16:0] q4,
                                              input logic [11:0] lim);
        logic signed [16:0] lim_q;
        lim_q = signed'({1'b0, lim, 4'b0000});
        if (q4 <= 17'sd0)
            return 12'd0;
        else if (q4 >= lim_q)
            return lim;
        else
            return q4[15:4];
    endfunction

    function automatic logic [12:0] map_prep(input logic [11:0] pix, input logic [11:0] pad);
        logic signed [12:0] d;
        logic [12:0] nd;
        d = signed'({1'b0, pix}) - signed'({1'b0, pad});
        nd = 13'(-d);
        return {d[12], d[12] ? nd[11:0] : d[11:0]};
    endfunction

    // config registers
    logic [15:0] iou_thr_reg, score_thr_reg;
    logic [11:0] model_w_reg, model_h_reg, pad_left_reg, pad_top_reg;
    logic [19:0] inv_w_reg, inv_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iou_thr_reg   <= 16'd29491;
            score_thr_reg <= 16'd16384;
            model_w_reg   <= 12'd640;
            model_h_reg   <= 12'd640;
            pad_left_reg  <= 12'd0;
            pad_top_reg   <= 12'd0;
            inv_w_reg     <= 20'd65536;
            inv_h_reg     <= 20'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_IOU_THR:   iou_thr_reg   <= cfg_data[15:0];
                REG_SCORE_THR: score_thr_reg <= cfg_data[15:0];
                REG_MODEL_W:   model_w_reg   <= cfg_data[11:0];
                REG_MODEL_H:   model_h_reg   <= cfg_data[11:0];
                REG_PAD_LEFT:  pad_left_reg  <= cfg_data[11:0];
                REG_PAD_TOP:   pad_top_reg   <= cfg_data[11:0];
                REG_INV_W:     inv_w_reg     <= cfg_data[19:0];
                REG_INV_H:     inv_h_reg     <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // stores: box {h,w,top,left}, {class,score}, sorted order, suppressed flags
    logic [61:0]   box_mem [MAX_CANDIDATES];
    logic [23:0]   sc_mem  [MAX_CANDIDATES];
    logic [IW-1:0] ord_mem [MAX_CANDIDATES];
    logic          sup_mem [MAX_CANDIDATES];
    logic [61:0]   box_q;
    logic [23:0]   sc_q;
    logic [IW-1:0] ord_q;
    logic          sup_q;
    logic [IW-1:0] baddr;

    assign baddr = cmd.box_sel_order ? ord_q : box_idx;

    always_ff @(posedge aclk) begin
        if (cmd.store_we) begin
            box_mem[pos] <= s_tdata[61:0];
            sc_mem[pos]  <= s_tdata[85:62];
        end
        if (cmd.store_we || cmd.sup_set)
            sup_mem[pos] <= cmd.sup_set;
        if (cmd.order_we)
            ord_mem[ord_addr] <= ord_val;
        box_q <= box_mem[baddr];
        sc_q  <= sc_mem[baddr];
        ord_q <= ord_mem[pos];
        sup_q <= sup_mem[pos];
    end

    // reference box A
    logic [61:0] a_box_reg;
    logic [23:0] a_sc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.a_load) begin
            a_box_reg <= box_q;
            a_sc_reg  <= sc_q;
        end
    end

    // overlap pipeline, four stages
    logic signed [17:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic signed [17:0] lox, hix, loy, hiy;
    logic signed [18:0] dx, dy;
    logic [15:0] iw_reg, ih_reg, wa_reg, ha_reg, wb_reg, hb_reg;
    logic [31:0] inter_reg, area_a_reg, area_b_reg, inter3_reg, uni_reg;
    logic [47:0] thr_prod;
    logic        ovl_reg;

    always_comb begin
        ax0 = 18'(signed'(a_box_reg[15:0]));
        ay0 = 18'(signed'(a_box_reg[31:16]));
        ax1 = ax0 + signed'({3'b000, a_box_reg[46:32]});
        ay1 = ay0 + signed'({3'b000, a_box_reg[61:47]});
        bx0 = 18'(signed'(box_q[15:0]));
        by0 = 18'(signed'(box_q[31:16]));
        bx1 = bx0 + signed'({3'b000, box_q[46:32]});
        by1 = by0 + signed'({3'b000, box_q[61:47]});
        lox = (ax0 > bx0) ? ax0 : bx0;
        hix = (ax1 < bx1) ? ax1 : bx1;
        loy = (ay0 > by0) ? ay0 : by0;
        hiy = (ay1 < by1) ? ay1 : by1;
        dx  = 19'(hix) - 19'(lox) + 19'sd16;
        dy  = 19'(hiy) - 19'(loy) + 19'sd16;
        thr_prod = iou_thr_reg * uni_reg;
    end

    always_ff @(posedge aclk) begin
        iw_reg     <= (!dx[18] && dx != 19'sd0) ? dx[15:0] : 16'd0;
        ih_reg     <= (!dy[18] && dy != 19'sd0) ? dy[15:0] : 16'd0;
        wa_reg     <= {1'b0, a_box_reg[46:32]} + 16'd16;
        ha_reg     <= {1'b0, a_box_reg[61:47]} + 16'd16;
        wb_reg     <= {1'b0, box_q[46:32]} + 16'd16;
        hb_reg     <= {1'b0, box_q[61:47]} + 16'd16;
        inter_reg  <= iw_reg * ih_reg;
        area_a_reg <= wa_reg * ha_reg;
        area_b_reg <= wb_reg * hb_reg;
        inter3_reg <= inter_reg;
        uni_reg    <= area_a_reg + area_b_reg - inter_reg;
        ovl_reg    <= {inter3_reg, 16'h0000} > thr_prod;
    end

    // emit mapping: clamp, then offset and scale, then sign restore
    logic [3:0][11:0] clamp_reg;
    logic [3:0][31:0] prod_reg;
    logic [3:0]       neg_reg;
    logic [3:0][16:0] coord;
    logic [3:0][12:0] prep;
    logic [16:0]      bx1_q4, by1_q4;

    always_comb begin
        bx1_q4 = {box_q[15], box_q[15:0]} + {2'b00, box_q[46:32]};
        by1_q4 = {box_q[31], box_q[31:16]} + {2'b00, box_q[61:47]};
        for (int k = 0; k < 4; k++) begin
            prep[k] = map_prep(clamp_reg[k], k[0] ? pad_top_reg : pad_left_reg);
            coord[k] = neg_reg[k] ? 17'(-{1'b0, prod_reg[k][31:16]})
                                  : {1'b0, prod_reg[k][31:16]};
        end
    end

    always_ff @(posedge aclk) begin
        clamp_reg[0] <= clamp_pix(17'(signed'(box_q[15:0])), model_w_reg);
        clamp_reg[1] <= clamp_pix(17'(signed'(box_q[31:16])), model_h_reg);
        clamp_reg[2] <= clamp_pix(signed'(bx1_q4), model_w_reg);
        clamp_reg[3] <= clamp_pix(signed'(by1_q4), model_h_reg);
        for (int k = 0; k < 4; k++) begin
            neg_reg[k]  <= prep[k][12];
            prod_reg[k] <= prep[k][11:0] * (k[0] ? inv_h_reg : inv_w_reg);
        end
    end

    // result, pending result and output register; layout matches m_tdata
    logic [91:0] res_reg, pend_reg, out_data_reg;
    logic        out_valid_reg, out_res_reg, out_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_load)
            res_reg <= {sc_q[23:16], sc_q[15:0], coord[3], coord[2], coord[1], coord[0]};
        if (cmd.pend_load)
            pend_reg <= res_reg;
        if (cmd.out_load) begin
            out_data_reg <= cmd.out_empty ? 92'd0 : pend_reg;
            out_res_reg  <= !cmd.out_empty;
            out_last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};
    assign m_tuser  = out_res_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        stat.class_ok = {1'b0, s_tdata[85:78]} < 9'(NUM_CLASSES);
        stat.score_gt = sc_q[15:0] > a_sc_reg[15:0];
        stat.score_eq = sc_q[15:0] == a_sc_reg[15:0];
        stat.class_eq = sc_q[23:16] == a_sc_reg[23:16];
        stat.sup_bit  = sup_q;
        stat.overlap  = ovl_reg;
        stat.keep_ok  = !sup_q && (sc_q[15:0] >= score_thr_reg);
        stat.out_free = !out_valid_reg || m_tready;
    end

endmodule

// File: design/class_aware_box_nms.sv
// Top level of the class-aware box suppression block.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready  | s_tdata candidate box, s_tlast frame end
//  m_      | out | m_tvalid / m_tready  | m_tdata kept box, m_tuser box flag,
//          |     |                      | m_tlast end of list
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// Phases: candidate words are accepted while loading. The frame-end word starts
// ranking (each stored box against every stored box), pairwise suppression
// (same-class pairs through the overlap pipeline, already suppressed and
// other-class pairs skipped) and emit (kept boxes mapped, others passed by). The
// single read port on each store paces every phase.
// Reset: synchronous, active-low aresetn; registers return to their defaults
// and the candidate count to zero.
// Stalls: one finished word waits in the output register while the next is
// prepared; the emit sequence holds when a second word is ready and m_tready
// is low. s_tready is high only while boxes are being loaded.
`timescale 1ns / 1ps
module class_aware_box_nms #(
    parameter int MAX_CANDIDATES = 256,
    parameter int MAX_KEPT = 64,
    parameter int NUM_CLASSES = 80
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // lowest bit up: box_left 16, box_top 16, box_width 15, box_height 15,
    // score 16, class_index 8, zero fill 2
    input  logic [cabn_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                 s_tvalid,
    input  logic                                 s_tlast,
    output logic                                 s_tready,
    // lowest bit up: x_min 17, y_min 17, x_max 17, y_max 17, kept_score 16,
    // kept_class 8, zero fill 4
    output logic [cabn_pkg::M_TDATA_W-1:0]       m_tdata,
    // valid_res
    output logic [cabn_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                 m_tvalid,
    output logic                                 m_tlast,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cabn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cabn_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cabn_pkg::*;

    localparam int IW = $clog2(MAX_CANDIDATES);

    cmd_t          cmd;
    stat_t         stat;
    logic [IW-1:0] pos, box_idx, ord_addr, ord_val;

    // registers are always writable; write them only between frames
    assign cfg_ready = 1'b1;

    cabn_ctrl #(
        .MAX_CANDIDATES(MAX_CANDIDATES),
        .MAX_KEPT(MAX_KEPT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .pos      (pos),
        .box_idx  (box_idx),
        .ord_addr (ord_addr),
        .ord_val  (ord_val)
    );

    cabn_dp #(
        .MAX_CANDIDATES(MAX_CANDIDATES),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .pos       (pos),
        .box_idx   (box_idx),
        .ord_addr  (ord_addr),
        .ord_val   (ord_val),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: design/cabn_checker.sv
// Port-level checks for the class-aware box suppression block.
`timescale 1ns / 1ps
module cabn_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cabn_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [cabn_pkg::M_TUSER_W-1:0]   m_tuser,
    input logic                             m_tlast
);
    import cabn_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty word not marked end of list");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty word carries data");

    a_frame_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after frame end");

endmodule

bind class_aware_box_nms cabn_checker u_cabn_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the class-aware box suppression block.
`timescale 1ns / 1ps
module testbench;
    import cabn_pkg::*;

    localparam int NCAND = 256;
    localparam int NKEPT = 64;
    localparam int NCLS  = 80;
    localparam int WATCHDOG_LIMIT = 2000000;

    typedef struct packed {
        logic        valid_res;
        logic [16:0] x_min;
        logic [16:0] y_min;
        logic [16:0] x_max;
        logic [16:0] y_max;
        logic [15:0] kept_score;
        logic [7:0]  kept_class;
        logic        end_of_list;
    } kept_box_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0, s_tlast = 1'b0, s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic m_tvalid, m_tlast;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    class_aware_box_nms u_top (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor copy of the register file and frame store
    logic [15:0] iou_thr, score_thr;
    logic [11:0] model_w, model_h, pad_l, pad_t;
    logic [19:0] inv_w, inv_h;
    int frame_left[NCAND], frame_top[NCAND], frame_w[NCAND], frame_h[NCAND];
    int frame_score[NCAND], frame_cls[NCAND];
    int frame_count;

    kept_box_t kept_q[$];
    int error_count = 0;
    bit calm = 0;       // stretch with no idling on either side
    int idle_cnt = 0;

    function automatic bit is_overlapping(int a, int b);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, iw, ih, inter, uni;
        ax0 = frame_left[a]; ay0 = frame_top[a];
        ax1 = ax0 + frame_w[a]; ay1 = ay0 + frame_h[a];
        bx0 = frame_left[b]; by0 = frame_top[b];
        bx1 = bx0 + frame_w[b]; by1 = by0 + frame_h[b];
        iw = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0) + 16;
        ih = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0) + 16;
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni = (ax1 - ax0 + 16) * (ay1 - ay0 + 16) + (bx1 - bx0 + 16) * (by1 - by0 + 16) - inter;
        if (uni <= 0) return 0;
        return inter * 65536 > longint'(iou_thr) * uni;
    endfunction

    function automatic int to_pixel(int q4, int lim);
        if (q4 <= 0) return 0;
        if (longint'(q4) >= longint'(lim) * 16) return lim;
        return q4 >>> 4;
    endfunction

    function automatic logic [16:0] to_original(int pix, int pad, longint inv);
        longint d, mag, q;
        d = pix - pad;
        mag = (d < 0) ? -d : d;
        q = (mag * inv) >>> 16;
        return (d < 0) ? 17'(-q) : 17'(q);
    endfunction

    // Whole-frame suppression: rank, suppress per class, emit survivors.
    task automatic run_suppression();
        int order[NCAND];
        bit gone[NCAND];
        int i, j, v, kept, b;
        kept_box_t r;
        kept = 0;
        for (i = 0; i < frame_count; i++) begin
            v = i; j = i;
            while (j > 0 && frame_score[order[j-1]] < frame_score[v]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
            gone[i] = 0;
        end
        for (i = 0; i < frame_count; i++) begin
            if (gone[i]) continue;
            for (j = i + 1; j < frame_count; j++) begin
                if (gone[j] || frame_cls[order[j]] != frame_cls[order[i]]) continue;
                if (is_overlapping(order[i], order[j])) gone[j] = 1;
            end
        end
        for (i = 0; i < frame_count && kept < NKEPT; i++) begin
            b = order[i];
            if (gone[i] || frame_score[b] < score_thr) continue;
            r.valid_res = 1'b1;
            r.x_min = to_original(to_pixel(frame_left[b], model_w), pad_l, inv_w);
            r.y_min = to_original(to_pixel(frame_top[b], model_h), pad_t, inv_h);
            r.x_max = to_original(to_pixel(frame_left[b] + frame_w[b], model_w), pad_l, inv_w);
            r.y_max = to_original(to_pixel(frame_top[b] + frame_h[b], model_h), pad_t, inv_h);
            r.kept_score = 16'(frame_score[b]);
            r.kept_class = 8'(frame_cls[b]);
            r.end_of_list = 1'b0;
            kept_q.push_back(r);
            kept++;
        end
        if (kept == 0) begin
            r = '0;
            r.end_of_list = 1'b1;
            kept_q.push_back(r);
        end else begin
            kept_q[kept_q.size()-1].end_of_list = 1'b1;
        end
        frame_count = 0;
    endtask

    task automatic predict_box(logic [S_TDATA_W-1:0] d, logic lst);
        if (frame_count < NCAND && d[85:78] < NCLS) begin
            frame_left[frame_count]  = $signed(d[15:0]);
            frame_top[frame_count]   = $signed(d[31:16]);
            frame_w[frame_count]     = d[46:32];
            frame_h[frame_count]     = d[61:47];
            frame_score[frame_count] = d[77:62];
            frame_cls[frame_count]   = d[85:78];
            frame_count++;
        end
        if (lst) run_suppression();
    endtask

    function automatic bit want_idle();
        return !calm && ($urandom_range(99) < 31);
    endfunction

    // send one candidate word; prediction runs at acceptance
    task automatic send_box(logic signed [15:0] l, logic signed [15:0] t, logic [14:0] w,
                            logic [14:0] h, logic [15:0] sc, logic [7:0] cls, logic lst);
        logic [S_TDATA_W-1:0] d;
        d = {2'b00, cls, sc, h, w, t, l};
        cfg_valid <= 1'b0;
        while (want_idle()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= d;
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_box(d, lst);
    endtask

    // a write is closed by the next send_box
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_IOU_THR:   iou_thr   = val[15:0];
            REG_SCORE_THR: score_thr = val[15:0];
            REG_MODEL_W:   model_w   = val[11:0];
            REG_MODEL_H:   model_h   = val[11:0];
            REG_PAD_LEFT:  pad_l     = val[11:0];
            REG_PAD_TOP:   pad_t     = val[11:0];
            REG_INV_W:     inv_w     = val;
            default:       inv_h     = val;
        endcase
    endtask

    // drain: all results in, then some slack for the block to return to load
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (kept_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // random box; most boxes fall in a bounded area so suppression actually fires
    task automatic send_random(logic lst, int ncls);
        logic signed [15:0] l, t;
        l = 16'($urandom_range(9000) - 1000);
        t = 16'($urandom_range(9000) - 1000);
        if ($urandom_range(9) == 0) begin
            l = 16'($urandom); t = 16'($urandom);
        end
        send_box(l, t, $urandom_range(9) == 0 ? 15'($urandom) : 15'($urandom_range(3000)),
                 $urandom_range(9) == 0 ? 15'($urandom) : 15'($urandom_range(3000)),
                 $urandom_range(3) == 0 ? 16'($urandom_range(3) * 16384) : 16'($urandom),
                 $urandom_range(19) == 0 ? 8'($urandom) : 8'($urandom_range(ncls - 1)), lst);
    endtask

    task automatic test_directed_extremes();
        send_box(16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 16'hffff, 8'd0, 1'b0);
        send_box(16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 16'hffff, 8'd0, 1'b0);
        send_box(16'sd100, 16'sd100, 15'd0, 15'd0, 16'd0, 8'd79, 1'b0);
        send_box(16'sd160, 16'sd160, 15'd800, 15'd800, 16'd40000, 8'd3, 1'b0);
        send_box(16'sd170, 16'sd165, 15'd800, 15'd800, 16'd40000, 8'd3, 1'b0); // tie, overlap
        send_box(16'sd170, 16'sd165, 15'd800, 15'd800, 16'd50000, 8'd4, 1'b0); // other class
        send_box(16'sd10, 16'sd10, 15'd50, 15'd50, 16'hffff, 8'd80, 1'b0);   // class dropped
        send_box(16'sd10, 16'sd10, 15'd50, 15'd50, 16'hffff, 8'hff, 1'b0);
        send_box(-16'sd300, 16'sd9000, 15'd200, 15'd20000, 16'd16383, 8'd5, 1'b0); // low score
        send_box(-16'sd300, 16'sd9000, 15'd200, 15'd20000, 16'd16384, 8'd5, 1'b1);
        wait_idle();
        // nothing survives: only dropped classes and low scores
        send_box(16'sd0, 16'sd0, 15'd10, 15'd10, 16'hffff, 8'd200, 1'b0);
        send_box(16'sd0, 16'sd0, 15'd10, 15'd10, 16'd1, 8'd1, 1'b1);
        wait_idle();
        send_box(16'sd0, 16'sd0, 15'd10, 15'd10, 16'hffff, 8'd80, 1'b1); // empty frame
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_IOU_THR, 20'h0);
        write_reg(REG_SCORE_THR, 20'h0);
        write_reg(REG_MODEL_W, 20'd1);
        write_reg(REG_MODEL_H, 20'hfff);
        write_reg(REG_PAD_LEFT, 20'hfff);
        write_reg(REG_PAD_TOP, 20'd0);
        write_reg(REG_INV_W, 20'hfffff);
        write_reg(REG_INV_H, 20'd0);
        repeat (6) send_random(1'b0, 4);
        send_random(1'b1, 4);
        wait_idle();
        write_reg(REG_IOU_THR, 20'hffff);
        write_reg(REG_SCORE_THR, 20'hffff);
        write_reg(REG_MODEL_W, 20'hfff);
        write_reg(REG_MODEL_H, 20'd1);
        write_reg(REG_PAD_LEFT, 20'd0);
        write_reg(REG_PAD_TOP, 20'hfff);
        write_reg(REG_INV_W, 20'd1);
        write_reg(REG_INV_H, 20'hfffff);
        repeat (5) send_random(1'b0, 2);
        send_box(16'sd0, 16'sd0, 15'd10, 15'd10, 16'hffff, 8'd0, 1'b1);
        wait_idle();
    endtask

    // store overflow: more boxes than the store holds in one frame
    task automatic test_store_full();
        write_reg(REG_SCORE_THR, 20'd60000);
        write_reg(REG_IOU_THR, 20'd29491);
        write_reg(REG_MODEL_W, 20'd640);
        write_reg(REG_MODEL_H, 20'd640);
        calm = 1;
        for (int i = 0; i < NCAND + 3; i++)
            send_box(16'(i * 40), 16'(i * 20), 15'd30, 15'd30,
                     i >= NCAND ? 16'hffff : 16'(60000 + i), 8'(i % 3), i == NCAND + 2);
        calm = 0;
        wait_idle();
    endtask

    // short random frames; the store test above carries most of the items
    task automatic test_random_frames();
        int sent;
        sent = 0;
        for (int f = 0; sent < 24; f++) begin
            int nbox;
            write_reg(REG_IOU_THR, 20'($urandom_range(65535)));
            write_reg(REG_SCORE_THR, 20'($urandom_range(40000)));
            write_reg(REG_MODEL_W, 20'($urandom_range(4095, 1)));
            write_reg(REG_MODEL_H, 20'($urandom_range(4095, 1)));
            write_reg(REG_PAD_LEFT, 20'($urandom_range(200)));
            write_reg(REG_PAD_TOP, 20'($urandom_range(4095)));
            write_reg(REG_INV_W, 20'($urandom_range(1048575, 1)));
            write_reg(REG_INV_H, 20'($urandom_range(200000, 1)));
            calm = (f % 8 == 3);
            nbox = $urandom_range(16, 1);
            for (int k = 0; k < nbox; k++) send_random(k == nbox - 1, $urandom_range(4, 1));
            sent += nbox;
            wait_idle();
        end
        calm = 0;
    endtask

    // result side: random stall and checking against oldest expectation
    always @(posedge aclk) begin
        kept_box_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[16:0], m_tdata[33:17], m_tdata[50:34],
                       m_tdata[67:51], m_tdata[83:68], m_tdata[91:84], m_tlast};
                if (kept_q.size() == 0) begin
                    $error("unexpected result word %h", got);
                    error_count++;
                end else begin
                    want = kept_q.pop_front();
                    if (got.valid_res != want.valid_res) begin
                        $error("valid_res exp %0d got %0d", want.valid_res, got.valid_res);
                        error_count++;
                    end
                    if (got.x_min != want.x_min) begin
                        $error("x_min exp %0d got %0d", $signed(want.x_min), $signed(got.x_min));
                        error_count++;
                    end
                    if (got.y_min != want.y_min) begin
                        $error("y_min exp %0d got %0d", $signed(want.y_min), $signed(got.y_min));
                        error_count++;
                    end
                    if (got.x_max != want.x_max) begin
                        $error("x_max exp %0d got %0d", $signed(want.x_max), $signed(got.x_max));
                        error_count++;
                    end
                    if (got.y_max != want.y_max) begin
                        $error("y_max exp %0d got %0d", $signed(want.y_max), $signed(got.y_max));
                        error_count++;
                    end
                    if (got.kept_score != want.kept_score) begin
                        $error("kept_score exp %0d got %0d", want.kept_score, got.kept_score);
                        error_count++;
                    end
                    if (got.kept_class != want.kept_class) begin
                        $error("kept_class exp %0d got %0d", want.kept_class, got.kept_class);
                        error_count++;
                    end
                    if (got.end_of_list != want.end_of_list) begin
                        $error("end_of_list exp %0d got %0d", want.end_of_list,
                               got.end_of_list);
                        error_count++;
                    end
                end
            end
            m_tready <= !want_idle();
        end
    end

    // watchdog: cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        iou_thr = 16'd29491; score_thr = 16'd16384;
        model_w = 12'd640; model_h = 12'd640;
        pad_l = '0; pad_t = '0;
        inv_w = 20'd65536; inv_h = 20'd65536;
        frame_count = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_config_extremes();
        test_store_full();
        test_random_frames();
        wait_idle();
        repeat (200) @(posedge aclk);
        if (error_count == 0 && kept_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
